@@ sv/grid_vector_interpolator_assert.svh @@
// assertion macros for the grid vector interpolator
`ifndef GRID_VECTOR_INTERPOLATOR_ASSERT_SVH
`define GRID_VECTOR_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, off during reset
`define GVI_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("gvi assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define GVI_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("gvi assertion failed");

`else

`define GVI_ASSERT_NOW(lbl, pre, post)
`define GVI_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

@@ sv/gvi_pkg.sv @@
// shared types, constants and interpolation arithmetic for the grid vector interpolator
`default_nettype none

package gvi_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int VALUE_WIDTH = 16;
    localparam int COORD_WIDTH = 11;
    localparam int REQ_WIDTH   = 2;

    // sixteen corners at most, one bit per interpolated axis
    localparam int CORNER_BITS = 4;

    localparam logic [REQ_WIDTH-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_WIDTH-1:0] REQ_SPACE = 2'd1;
    localparam logic [REQ_WIDTH-1:0] REQ_PARAM = 2'd2;

    localparam logic [CORNER_BITS-1:0] LAST_PLANE = 4'd3;
    localparam logic [CORNER_BITS-1:0] LAST_FULL  = 4'd15;

    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    typedef logic [FRAC_BITS-1:0]          frac_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    localparam logic signed [VALUE_WIDTH+1:0] SUM_MAX =
        (VALUE_WIDTH+2)'((1 << (VALUE_WIDTH - 1)) - 1);
    localparam logic signed [VALUE_WIDTH+1:0] SUM_MIN =
        (VALUE_WIDTH+2)'(-(1 << (VALUE_WIDTH - 1)));

    typedef struct packed {
        logic [REQ_WIDTH-1:0]   req_type;
        logic [COORD_WIDTH-1:0] coord_s;
        logic [COORD_WIDTH-1:0] coord_t;
        logic [COORD_WIDTH-1:0] coord_x;
        logic [COORD_WIDTH-1:0] coord_y;
        value_t                 write_first;
        value_t                 write_second;
    } gvi_req_t;

    typedef struct packed {
        value_t result_first;
        value_t result_second;
    } gvi_rsp_t;

    // one grid entry, second component in the upper half
    typedef struct packed {
        value_t second;
        value_t first;
    } entry_t;

    typedef struct packed {
        logic                   vld;
        logic [CORNER_BITS-1:0] corner;
    } rd_tag_t;

    typedef struct packed {
        logic plane_vld;
        logic full_vld;
    } reduce_done_t;

    // a + floor(((b - a) * f + half) / 2^frac), saturated
    function automatic value_t lerp(value_t a, value_t b, frac_t f);
        logic signed [VALUE_WIDTH:0]             diff;
        logic signed [VALUE_WIDTH+FRAC_BITS+1:0] prod;
        logic signed [VALUE_WIDTH+1:0]           step;
        logic signed [VALUE_WIDTH+1:0]           sum;
        diff = $signed({b[VALUE_WIDTH-1], b}) - $signed({a[VALUE_WIDTH-1], a});
        prod = diff * $signed({1'b0, f});
        prod = prod + (VALUE_WIDTH+FRAC_BITS+2)'(ROUND_HALF);
        step = prod[VALUE_WIDTH+FRAC_BITS+1:FRAC_BITS];
        sum  = $signed({{2{a[VALUE_WIDTH-1]}}, a}) + step;
        if (sum > SUM_MAX) begin
            sum = SUM_MAX;
        end
        else if (sum < SUM_MIN) begin
            sum = SUM_MIN;
        end
        return sum[VALUE_WIDTH-1:0];
    endfunction

    function automatic entry_t lerp_entry(entry_t a, entry_t b, frac_t f);
        entry_t r;
        r.first  = lerp(a.first, b.first, f);
        r.second = lerp(a.second, b.second, f);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/gvi_reduce.sv @@
// corner reduction tree: one lerp stage per axis, y then x then t then s
`default_nettype none

module gvi_reduce
    import gvi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rd_tag_t      rd_tag,
    input  entry_t       rd_data,
    input  frac_t        frac_s,
    input  frac_t        frac_t_in,
    input  frac_t        frac_x,
    input  frac_t        frac_y,
    output entry_t       plane_res,
    output entry_t       full_res,
    output reduce_done_t done
);

    entry_t     y_even_reg;
    entry_t     y_res_reg;
    logic       y_vld_reg;
    logic [2:0] y_idx_reg;

    entry_t     x_even_reg;
    entry_t     x_res_reg;
    logic       x_vld_reg;
    logic [1:0] x_idx_reg;

    entry_t     t_even_reg;
    entry_t     t_res_reg;
    logic       t_vld_reg;
    logic       t_idx_reg;

    entry_t     s_even_reg;
    entry_t     s_res_reg;
    logic       s_vld_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_vld_reg <= 1'b0;
            x_vld_reg <= 1'b0;
            t_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end
        else
        begin
            y_vld_reg <= rd_tag.vld & rd_tag.corner[0];
            x_vld_reg <= y_vld_reg & y_idx_reg[0];
            t_vld_reg <= x_vld_reg & x_idx_reg[0];
            s_vld_reg <= t_vld_reg & t_idx_reg;
        end
    end

    // values: even partner held, odd partner combined
    always_ff @(posedge clk)
    begin
        if (rd_tag.vld)
        begin
            if (!rd_tag.corner[0])
            begin
                y_even_reg <= rd_data;
            end
            else
            begin
                y_res_reg <= lerp_entry(y_even_reg, rd_data, frac_y);
                y_idx_reg <= rd_tag.corner[3:1];
            end
        end
        if (y_vld_reg)
        begin
            if (!y_idx_reg[0])
            begin
                x_even_reg <= y_res_reg;
            end
            else
            begin
                x_res_reg <= lerp_entry(x_even_reg, y_res_reg, frac_x);
                x_idx_reg <= y_idx_reg[2:1];
            end
        end
        if (x_vld_reg)
        begin
            if (!x_idx_reg[0])
            begin
                t_even_reg <= x_res_reg;
            end
            else
            begin
                t_res_reg <= lerp_entry(t_even_reg, x_res_reg, frac_t_in);
                t_idx_reg <= x_idx_reg[1];
            end
        end
        if (t_vld_reg)
        begin
            if (!t_idx_reg)
            begin
                s_even_reg <= t_res_reg;
            end
            else
            begin
                s_res_reg <= lerp_entry(s_even_reg, t_res_reg, frac_s);
            end
        end
    end

    assign plane_res      = x_res_reg;
    assign full_res       = s_res_reg;
    assign done.plane_vld = x_vld_reg;
    assign done.full_vld  = s_vld_reg;

endmodule

`default_nettype wire

@@ sv/grid_vector_interpolator.sv @@
// top level: grid store, read sequencer and result register of the grid vector interpolator
// sequence: a write is stored on the accepting edge; a query reads its corners (four for
//   space, sixteen for parameter) through the registered read and the reduction tree
//   into the result register; no new item is taken until that result is loaded, and
//   the single grid memory port serves one corner read per cycle
// reset: control state clears asynchronously; the grid store is not cleared
`default_nettype none

module grid_vector_interpolator
    import gvi_pkg::*;
#(
    parameter int GRID_SIZE = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  gvi_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output gvi_rsp_t rsp_data
);

    `include "grid_vector_interpolator_assert.svh"

    // grid geometry
    localparam int AXIS_BITS  = $clog2(GRID_SIZE);
    localparam int DEPTH      = GRID_SIZE * GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int ADDR_BITS  = $clog2(DEPTH);
    localparam int CLAMP_TOP  = (GRID_SIZE - 1) << FRAC_BITS;
    localparam int CLAMP_BITS = (AXIS_BITS + FRAC_BITS > COORD_WIDTH) ?
                                (AXIS_BITS + FRAC_BITS) : COORD_WIDTH;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    // one coordinate after clamping: floor, ceiling and fraction
    typedef struct packed {
        logic [AXIS_BITS-1:0] lo;
        logic [AXIS_BITS-1:0] hi;
        frac_t                frac;
    } axis_t;

    // clamp to the last grid point, ceiling equals floor on a zero fraction
    function automatic axis_t split_axis(logic [COORD_WIDTH-1:0] c);
        logic [CLAMP_BITS-1:0] cz;
        axis_t                 a;
        cz = CLAMP_BITS'(c);
        if (cz > CLAMP_BITS'(CLAMP_TOP))
        begin
            cz = CLAMP_BITS'(CLAMP_TOP);
        end
        a.lo   = cz[AXIS_BITS+FRAC_BITS-1:FRAC_BITS];
        a.frac = cz[FRAC_BITS-1:0];
        a.hi   = a.lo + AXIS_BITS'(a.frac != '0);
        return a;
    endfunction

    // row-major entry address, s outermost and y innermost
    function automatic logic [ADDR_BITS-1:0] cell_addr(
        logic [AXIS_BITS-1:0] s,
        logic [AXIS_BITS-1:0] t,
        logic [AXIS_BITS-1:0] x,
        logic [AXIS_BITS-1:0] y
    );
        logic [ADDR_BITS-1:0] g;
        g = ADDR_BITS'(GRID_SIZE);
        return ((ADDR_BITS'(s) * g + ADDR_BITS'(t)) * g + ADDR_BITS'(x)) * g
               + ADDR_BITS'(y);
    endfunction

    // grid store: single port, registered read
    entry_t grid_mem [DEPTH];

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [CORNER_BITS-1:0] corner_reg;
    logic [CORNER_BITS-1:0] corner_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    rd_tag_t                rd_tag_reg;
    rd_tag_t                rd_tag_next;

    // query payload held for the whole read sweep
    logic   is_param_reg;
    axis_t  axis_s_reg;
    axis_t  axis_t_reg;
    axis_t  axis_x_reg;
    axis_t  axis_y_reg;
    entry_t rd_data_reg;
    gvi_rsp_t rsp_data_reg;

    axis_t  in_s;
    axis_t  in_t;
    axis_t  in_x;
    axis_t  in_y;
    entry_t wr_entry;

    logic accept;
    logic is_query;
    logic mem_we;
    logic mem_re;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [AXIS_BITS-1:0] rd_s;
    logic [AXIS_BITS-1:0] rd_t;
    logic [AXIS_BITS-1:0] rd_x;
    logic [AXIS_BITS-1:0] rd_y;
    logic [CORNER_BITS-1:0] last_corner;

    entry_t       plane_res;
    entry_t       full_res;
    entry_t       final_res;
    reduce_done_t done;
    logic         done_pulse;
    logic         out_free;
    logic         rsp_load;

    // input side: a new item is taken whenever the sequencer is idle,
    // even while the previous result still sits in the result register
    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    assign in_s = split_axis(req_data.coord_s);
    assign in_t = split_axis(req_data.coord_t);
    assign in_x = split_axis(req_data.coord_x);
    assign in_y = split_axis(req_data.coord_y);

    // writes go straight into the store on the accepting edge
    assign mem_we   = accept && (req_data.req_type == REQ_WRITE);
    assign is_query = accept && ((req_data.req_type == REQ_SPACE) ||
                                 (req_data.req_type == REQ_PARAM));
    assign wr_entry.first  = req_data.write_first;
    assign wr_entry.second = req_data.write_second;
    assign wr_addr = cell_addr(in_s.lo, in_t.lo, in_x.lo, in_y.lo);

    // corner counter bits pick floor or ceiling: bit 3 s, bit 2 t, bit 1 x, bit 0 y;
    // a space query only walks the four corners with s and t at their floor
    assign rd_s = corner_reg[3] ? axis_s_reg.hi : axis_s_reg.lo;
    assign rd_t = corner_reg[2] ? axis_t_reg.hi : axis_t_reg.lo;
    assign rd_x = corner_reg[1] ? axis_x_reg.hi : axis_x_reg.lo;
    assign rd_y = corner_reg[0] ? axis_y_reg.hi : axis_y_reg.lo;
    assign rd_addr = cell_addr(rd_s, rd_t, rd_x, rd_y);

    assign mem_re   = (state_reg == ST_READ);
    assign mem_addr = mem_we ? wr_addr : rd_addr;

    assign last_corner = is_param_reg ? LAST_FULL : LAST_PLANE;

    // reduction tree finishes after the x stage for a space query
    // and after the s stage for a parameter query
    assign done_pulse = is_param_reg ? done.full_vld : done.plane_vld;
    assign final_res  = is_param_reg ? full_res : plane_res;

    // result register is free when empty or being emptied this cycle
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign rsp_load = (state_reg == ST_HOLD) && out_free;

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_query)
                begin
                    state_next  = ST_READ;
                    corner_next = '0;
                end
            end
            ST_READ:
            begin
                corner_next = corner_reg + 1'b1;
                if (corner_reg == last_corner)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done_pulse)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory read data is tagged with the corner it belongs to
    assign rd_tag_next.vld    = mem_re;
    assign rd_tag_next.corner = corner_reg;

    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            corner_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            rd_tag_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            corner_reg    <= corner_next;
            rsp_valid_reg <= rsp_valid_next;
            rd_tag_reg    <= rd_tag_next;
        end
    end

    // grid store port: a write only happens in idle, so it never meets a read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_addr] <= wr_entry;
        end
        else if (mem_re)
        begin
            rd_data_reg <= grid_mem[mem_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            is_param_reg <= (req_data.req_type == REQ_PARAM);
            axis_s_reg   <= in_s;
            axis_t_reg   <= in_t;
            axis_x_reg   <= in_x;
            axis_y_reg   <= in_y;
        end
        if (rsp_load)
        begin
            rsp_data_reg.result_first  <= final_res.first;
            rsp_data_reg.result_second <= final_res.second;
        end
    end

    gvi_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_tag    (rd_tag_reg),
        .rd_data   (rd_data_reg),
        .frac_s    (axis_s_reg.frac),
        .frac_t_in (axis_t_reg.frac),
        .frac_x    (axis_x_reg.frac),
        .frac_y    (axis_y_reg.frac),
        .plane_res (plane_res),
        .full_res  (full_res),
        .done      (done)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // no store write while a query sweep or its result is under way
    `GVI_ASSERT_NOW(a_no_write_busy, state_reg != ST_IDLE, !mem_we)

    // every corner read returns tagged data in the next cycle
    `GVI_ASSERT_NEXT(a_read_tagged, state_reg == ST_READ, rd_tag_reg.vld)

    // the tree only completes a query after its read sweep has ended
    `GVI_ASSERT_NOW(a_done_in_drain, done_pulse, state_reg == ST_DRAIN)

    // a finished result waits while the result register is still occupied
    `GVI_ASSERT_NEXT(a_hold_waits, (state_reg == ST_HOLD) && !out_free, state_reg == ST_HOLD)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the grid vector interpolator: directed and random items
`timescale 1ns / 100ps

module tb_top;
    import gvi_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int GRID_N       = 8;
    localparam int CELLS        = GRID_N * GRID_N * GRID_N * GRID_N;
    localparam int FRAC_ONE     = 1 << FRAC_BITS;
    localparam int FRAC_MAX     = FRAC_ONE - 1;
    localparam int COORD_TOP    = (GRID_N - 1) << FRAC_BITS;
    localparam int COORD_MAX    = (1 << COORD_WIDTH) - 1;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 630;

    localparam logic [REQ_WIDTH-1:0] REQ_UNUSED = 2'd3;

    localparam value_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam value_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam longint SAT_HI  = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    localparam longint SAT_LO  = -SAT_HI - 1;

    // one coordinate after clamping: floor cell, ceiling cell, fraction
    typedef struct packed {
        logic [3:0] lo;
        logic [3:0] hi;
        frac_t      frac;
    } axis_split_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    gvi_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    gvi_rsp_t rsp_data;

    // own copy of the grid and which cells hold a value
    entry_t   grid_model   [CELLS];
    bit       grid_written [CELLS];
    gvi_rsp_t pending_vectors [$];
    gvi_rsp_t expected_vec;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;
    int cycle_count   = 0;
    int fail_count    = 0;
    int items_sent    = 0;
    int n_writes      = 0;
    int n_space       = 0;
    int n_param       = 0;
    int n_unused      = 0;
    int results_seen  = 0;

    grid_vector_interpolator #(.GRID_SIZE(GRID_N)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t run did not complete within %0d cycles", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic axis_split_t split_coord(input logic [COORD_WIDTH-1:0] c);
        axis_split_t a;
        int          v;
        v = int'(c);
        if (v > COORD_TOP)
            v = COORD_TOP;
        a.lo   = 4'(v >> FRAC_BITS);
        a.frac = frac_t'(v);
        a.hi   = a.lo + ((a.frac != '0) ? 4'd1 : 4'd0);
        return a;
    endfunction

    function automatic int cell_of(input int s, input int t, input int x, input int y);
        return ((s * GRID_N + t) * GRID_N + x) * GRID_N + y;
    endfunction

    function automatic longint component(input int idx, input bit second);
        entry_t e;
        e = grid_model[idx];
        return second ? longint'(e.second) : longint'(e.first);
    endfunction

    // a + floor(((b - a) * f + half) / 2^frac), rounded half up
    function automatic longint blend(input longint a, input longint b, input longint f);
        longint d;
        d = (b - a) * f + ROUND_HALF;
        return a + (d >>> FRAC_BITS);
    endfunction

    function automatic longint plane_blend(input int s, input int t, input axis_split_t ax,
                                           input axis_split_t ay, input bit second);
        longint v00, v01, v10, v11, r0, r1;
        v00 = component(cell_of(s, t, ax.lo, ay.lo), second);
        v01 = component(cell_of(s, t, ax.lo, ay.hi), second);
        v10 = component(cell_of(s, t, ax.hi, ay.lo), second);
        v11 = component(cell_of(s, t, ax.hi, ay.hi), second);
        r0  = blend(v00, v01, ay.frac);
        r1  = blend(v10, v11, ay.frac);
        return blend(r0, r1, ax.frac);
    endfunction

    function automatic gvi_rsp_t interp_vector(input gvi_req_t it);
        axis_split_t as, at, ax, ay;
        longint      v, p00, p01, p10, p11, q0, q1;
        gvi_rsp_t    r;
        int          part;
        as = split_coord(it.coord_s);
        at = split_coord(it.coord_t);
        ax = split_coord(it.coord_x);
        ay = split_coord(it.coord_y);
        r  = '0;
        for (part = 0; part < 2; part++)
        begin
            if (it.req_type == REQ_SPACE)
            begin
                v = plane_blend(as.lo, at.lo, ax, ay, part[0]);
            end
            else
            begin
                p00 = plane_blend(as.lo, at.lo, ax, ay, part[0]);
                p01 = plane_blend(as.lo, at.hi, ax, ay, part[0]);
                p10 = plane_blend(as.hi, at.lo, ax, ay, part[0]);
                p11 = plane_blend(as.hi, at.hi, ax, ay, part[0]);
                q0  = blend(p00, p01, at.frac);
                q1  = blend(p10, p11, at.frac);
                v   = blend(q0, q1, as.frac);
            end
            if (v > SAT_HI)
                v = SAT_HI;
            if (v < SAT_LO)
                v = SAT_LO;
            if (part == 0)
                r.result_first = value_t'(v);
            else
                r.result_second = value_t'(v);
        end
        return r;
    endfunction

    // true when every corner the query would read has been written
    function automatic bit corners_ready(input gvi_req_t it);
        axis_split_t as, at, ax, ay;
        int          c, s, t, x, y;
        bit          ok;
        as = split_coord(it.coord_s);
        at = split_coord(it.coord_t);
        ax = split_coord(it.coord_x);
        ay = split_coord(it.coord_y);
        ok = 1'b1;
        for (c = 0; c < 16; c++)
        begin
            s = (c[3] && it.req_type == REQ_PARAM) ? as.hi : as.lo;
            t = (c[2] && it.req_type == REQ_PARAM) ? at.hi : at.lo;
            x = c[1] ? ax.hi : ax.lo;
            y = c[0] ? ay.hi : ay.lo;
            if (!grid_written[cell_of(s, t, x, y)])
                ok = 1'b0;
        end
        return ok;
    endfunction

    // appends the vector a query will return to the expected queue
    function automatic void queue_result(input gvi_rsp_t v);
        pending_vectors.insert(pending_vectors.size(), v);
    endfunction

    // updates the grid copy for writes, queues the vector a query will return
    function automatic void apply_item(input gvi_req_t it);
        axis_split_t as, at, ax, ay;
        entry_t      e;
        int          idx;
        as = split_coord(it.coord_s);
        at = split_coord(it.coord_t);
        ax = split_coord(it.coord_x);
        ay = split_coord(it.coord_y);
        case (it.req_type)
            REQ_WRITE:
            begin
                idx               = cell_of(as.lo, at.lo, ax.lo, ay.lo);
                e.first           = it.write_first;
                e.second          = it.write_second;
                grid_model[idx]   = e;
                grid_written[idx] = 1'b1;
                n_writes++;
                items_sent++;
            end
            REQ_SPACE:
            begin
                queue_result(interp_vector(it));
                n_space++;
                items_sent++;
            end
            REQ_PARAM:
            begin
                queue_result(interp_vector(it));
                n_param++;
                items_sent++;
            end
            default:
                n_unused++;
        endcase
    endfunction

    // ---------------------------------------------------------------- receiver and checker

    // random stalls, or a long hold-off while hold_len counts down
    always @(posedge clk)
    begin
        if (hold_len > 0)
        begin
            rsp_ready <= 1'b0;
            hold_len = hold_len - 1;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic report_field(input string name, input value_t want, input value_t got);
        fail_count++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_vectors.size() == 0)
            begin
                fail_count++;
                $display("%0t unexpected result: expected none, actual %0d %0d",
                         $time, rsp_data.result_first, rsp_data.result_second);
            end
            else
            begin
                expected_vec = pending_vectors.pop_front();
                results_seen++;
                if (rsp_data.result_first !== expected_vec.result_first)
                    report_field("result_first", expected_vec.result_first,
                                 rsp_data.result_first);
                if (rsp_data.result_second !== expected_vec.result_second)
                    report_field("result_second", expected_vec.result_second,
                                 rsp_data.result_second);
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // offers one item and returns at the edge that accepts it; valid stays high
    // into the next call unless a gap is taken
    task automatic send_item(input gvi_req_t it);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3))
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        apply_item(it);
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            default: return value_t'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic gvi_req_t random_item();
        gvi_req_t it;
        it.req_type     = REQ_WIDTH'($urandom_range(0, 3));
        it.coord_s      = COORD_WIDTH'($urandom);
        it.coord_t      = COORD_WIDTH'($urandom);
        it.coord_x      = COORD_WIDTH'($urandom);
        it.coord_y      = COORD_WIDTH'($urandom);
        it.write_first  = value_t'($urandom);
        it.write_second = value_t'($urandom);
        return it;
    endfunction

    // a coordinate that lands in cell k, with a fraction the write drops
    function automatic logic [COORD_WIDTH-1:0] cell_coord(input int k);
        if (k == GRID_N - 1 && $urandom_range(0, 1))
            return COORD_WIDTH'($urandom_range(COORD_TOP, COORD_MAX));
        return COORD_WIDTH'((k << FRAC_BITS) | $urandom_range(0, FRAC_MAX));
    endfunction

    // a query coordinate whose floor is b; the last cell only clamps
    function automatic logic [COORD_WIDTH-1:0] patch_coord(input int b);
        int f;
        if (b == GRID_N - 1)
            return ($urandom_range(0, 1)) ? COORD_WIDTH'(COORD_TOP)
                                          : COORD_WIDTH'($urandom_range(COORD_TOP, COORD_MAX));
        case ($urandom_range(0, 5))
            0:       f = 0;
            1:       f = FRAC_MAX;
            2:       f = ROUND_HALF;
            default: f = $urandom_range(0, FRAC_MAX);
        endcase
        return COORD_WIDTH'((b << FRAC_BITS) | f);
    endfunction

    function automatic int corner_cell(input int b, input bit up);
        return b + ((up && b < GRID_N - 1) ? 1 : 0);
    endfunction

    task automatic send_query(input logic [REQ_WIDTH-1:0] kind, input int s, input int t,
                              input int x, input int y);
        gvi_req_t it;
        it         = random_item();
        it.req_type = kind;
        it.coord_s = COORD_WIDTH'(s);
        it.coord_t = COORD_WIDTH'(t);
        it.coord_x = COORD_WIDTH'(x);
        it.coord_y = COORD_WIDTH'(y);
        send_item(it);
    endtask

    // fills the sixteen corners of one hypercube, then queries inside it
    task automatic send_patch(input int n_queries);
        int       base [4];
        int       c, q;
        gvi_req_t it;
        for (c = 0; c < 4; c++)
            base[c] = $urandom_range(0, GRID_N - 1);
        for (c = 0; c < 16; c++)
        begin
            it.req_type     = REQ_WRITE;
            it.coord_s      = cell_coord(corner_cell(base[0], c[3]));
            it.coord_t      = cell_coord(corner_cell(base[1], c[2]));
            it.coord_x      = cell_coord(corner_cell(base[2], c[1]));
            it.coord_y      = cell_coord(corner_cell(base[3], c[0]));
            it.write_first  = pick_value();
            it.write_second = pick_value();
            send_item(it);
        end
        for (q = 0; q < n_queries; q++)
        begin
            it          = random_item();
            it.req_type = ($urandom_range(0, 2) == 0) ? REQ_SPACE : REQ_PARAM;
            it.coord_s  = patch_coord(base[0]);
            it.coord_t  = patch_coord(base[1]);
            it.coord_x  = patch_coord(base[2]);
            it.coord_y  = patch_coord(base[3]);
            send_item(it);
        end
    endtask

    // a query anywhere, sent only if all its corners hold values
    task automatic send_stray_query();
        gvi_req_t it;
        int       tries;
        for (tries = 0; tries < 40; tries++)
        begin
            it          = random_item();
            it.req_type = ($urandom_range(0, 1)) ? REQ_SPACE : REQ_PARAM;
            if (corners_ready(it))
            begin
                send_item(it);
                return;
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    // extremes, truncation of s and t, rounding at half, clamping, unused code
    task automatic test_directed();
        gvi_req_t it;
        int       c;
        send_idle_pct = 13;
        recv_idle_pct = 64;
        for (c = 0; c < 16; c++)
        begin
            it.req_type     = REQ_WRITE;
            it.coord_s      = COORD_WIDTH'(((c >> 3) & 1) * FRAC_ONE + ((c * 37) & FRAC_MAX));
            it.coord_t      = COORD_WIDTH'(((c >> 2) & 1) * FRAC_ONE + ((c * 91) & FRAC_MAX));
            it.coord_x      = COORD_WIDTH'(((c >> 1) & 1) * FRAC_ONE + ((c * 53) & FRAC_MAX));
            it.coord_y      = COORD_WIDTH'((c & 1) * FRAC_ONE + ((c * 29) & FRAC_MAX));
            it.write_first  = ($countones(c) % 2) ? VAL_MIN : VAL_MAX;
            it.write_second = ($countones(c) % 2) ? VAL_MAX : VAL_MIN;
            send_item(it);
        end
        // far corner written through clamped coordinates
        it.req_type     = REQ_WRITE;
        it.coord_s      = COORD_WIDTH'(COORD_MAX);
        it.coord_t      = COORD_WIDTH'(COORD_MAX);
        it.coord_x      = COORD_WIDTH'(COORD_MAX);
        it.coord_y      = COORD_WIDTH'(COORD_MAX);
        it.write_first  = pick_value();
        it.write_second = pick_value();
        send_item(it);

        send_query(REQ_SPACE, 0, 0, 0, 0);
        send_query(REQ_SPACE, 0, 0, 0, ROUND_HALF);
        send_query(REQ_SPACE, FRAC_ONE + FRAC_MAX, FRAC_MAX, FRAC_MAX, 1);
        send_query(REQ_PARAM, ROUND_HALF, ROUND_HALF, ROUND_HALF, ROUND_HALF);
        send_query(REQ_PARAM, FRAC_MAX, 1, ROUND_HALF, FRAC_MAX);
        send_query(REQ_PARAM, 0, 0, ROUND_HALF / 2, FRAC_MAX - ROUND_HALF / 2);
        send_query(REQ_PARAM, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_query(REQ_SPACE, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP);
        // unused code must leave no result and no trace in the grid
        it          = random_item();
        it.req_type = REQ_UNUSED;
        send_item(it);
        send_query(REQ_SPACE, 0, 0, 0, 0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int       stop_at;
        gvi_req_t it;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            send_patch($urandom_range(2, 6));
            case ($urandom_range(0, 5))
                0:
                begin
                    it          = random_item();
                    it.req_type = REQ_UNUSED;
                    send_item(it);
                end
                1:
                begin
                    it          = random_item();
                    it.req_type = REQ_WRITE;
                    send_item(it);
                end
                2:
                    send_stray_query();
                default:
                    ;
            endcase
        end
    endtask

    // receiver holds off while queries keep coming, so the input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = HOLD_CYCLES;
        send_patch(20);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(13, 64, PHASE_ITEMS);
        test_random_traffic(64, 13, PHASE_ITEMS);
        test_backpressure();
        test_random_traffic(0, 0, PHASE_ITEMS);

        req_valid <= 1'b0;
        while (pending_vectors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d writes, %0d space and %0d parameter queries, %0d unused codes",
                 n_writes, n_space, n_param, n_unused);
        $display("%0d results checked over %0d cycles, %0d failures",
                 results_seen, cycle_count, fail_count);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
